### rtl/tlvg_pkg.sv
// Package for the thick line vertex generator.
// Holds the widths, the reset value of the thickness register and the payload types.
// No dependencies.
package tlvg_pkg;

    localparam int CoordBits   = 16;
    localparam int VertexCount = 12;
    localparam int IdxBits     = 4;
    localparam int ThickBits   = 12;
    localparam int AddrBits    = 3;
    localparam int DataBits    = 32;
    localparam int RegThickness = 0;
    localparam logic [ThickBits-1:0] ThickReset = 12'd16;

    // Direction magnitudes and the squared length.
    localparam int MagBits  = CoordBits;
    localparam int SqBits   = 2 * MagBits;
    localparam int RadBits  = SqBits + 1 + 16;
    localparam int SqrtSteps = (RadBits + 1) / 2;
    localparam int PadBits  = 2 * SqrtSteps;
    localparam int RootBits = SqrtSteps;
    localparam int RemBits  = RootBits + 3;

    // Normalization divide: (m << 23) + len/2 over len, quotient of UBits.
    localparam int UBits      = 16;
    localparam int NumBits    = MagBits + 23 + 1;
    localparam int DivRemBits = RootBits + 1;
    localparam int ProdBits   = ThickBits + UBits;
    localparam int OffBits    = ThickBits + 1;
    localparam int SumBits    = CoordBits + 2;

    localparam logic [IdxBits-1:0] LastIdx = IdxBits'(VertexCount - 1);

    typedef struct packed {
        logic signed [CoordBits-1:0] bx;
        logic signed [CoordBits-1:0] by;
        logic signed [CoordBits-1:0] ex;
        logic signed [CoordBits-1:0] ey;
        logic                        neg_x;
        logic                        neg_y;
        logic                        degen;
        logic        [MagBits-1:0]   mx;
        logic        [MagBits-1:0]   my;
    } t_geom;

    typedef struct packed {
        logic signed [OffBits-1:0] px;
        logic signed [OffBits-1:0] py;
        logic signed [OffBits-1:0] hx;
        logic signed [OffBits-1:0] hy;
        logic signed [OffBits-1:0] fx;
        logic signed [OffBits-1:0] fy;
    } t_offs;

endpackage

### rtl/thick_line_vertex_gen.sv
// Top level of the thick line vertex generator: length, normalize, offset and vertex output.
// Depends on tlvg_pkg.
//
// Each input transaction carries one segment (begin and end point, signed Q12.4) and yields
// twelve output transactions: six vertices of a quad of the configured thickness around the
// segment, then six of a tapered cap past the end point, with vertex_index 0 to 11 and
// last_vertex on the twelfth. The pipeline has these register stages: two for the
// direction and its squares, one for the squared length, twenty-five one-bit stages of the
// square root, one setup and sixteen one-bit stages of the normalizing divide, one multiply
// and one rounding stage, then a vertex serializer and the output register. The pipeline
// holds many segments at once, but the serializer takes one segment at a time and sends
// one vertex per cycle while the output is not stalled, so later segments wait in the pipeline. A
// zero-length segment gives zero offsets and sets degenerate on all twelve vertices.
// All coordinates saturate. The thickness register (unsigned Q8.4, reset 1.0) lives at
// address 0 and may only be written while no segment is in flight.
module thick_line_vertex_gen
    import tlvg_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [AddrBits-1:0]         paddr,
    input  logic [DataBits-1:0]         pwdata,
    output logic [DataBits-1:0]         prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [CoordBits-1:0] i_begin_x,
    input  logic signed [CoordBits-1:0] i_begin_y,
    input  logic signed [CoordBits-1:0] i_end_x,
    input  logic signed [CoordBits-1:0] i_end_y,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [CoordBits-1:0] o_vertex_x,
    output logic signed [CoordBits-1:0] o_vertex_y,
    output logic [IdxBits-1:0]          o_vertex_index,
    output logic                        o_last_vertex,
    output logic                        o_degenerate
);

    // Thickness register.
    logic [ThickBits-1:0] r_thick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thick <= ThickReset;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_thick <= pwdata[ThickBits-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? DataBits'(r_thick) : '0;
    assign pready = 1'b1;

    // The whole pipeline moves together; it holds only when the rounding stage has a
    // finished segment that the serializer cannot take yet.
    logic w_adv, w_ser_load, w_ser_fin, w_emit;
    logic r_rd_v, r_ser_v;
    logic [IdxBits-1:0] r_cnt;
    logic r_o_v;

    assign w_adv      = !r_rd_v || w_ser_load;
    assign w_ser_load = r_rd_v && (!r_ser_v || w_ser_fin);
    assign w_emit     = r_ser_v && (!r_o_v || !i_out_stall);
    assign w_ser_fin  = w_emit && (r_cnt == LastIdx);
    assign o_in_stall = !w_adv;

    // Stage 1: direction, its sign and magnitude.
    logic signed [CoordBits:0] w_dx, w_dy;
    t_geom w_g0;
    assign w_dx = $signed({i_end_x[CoordBits-1], i_end_x})
                  - $signed({i_begin_x[CoordBits-1], i_begin_x});
    assign w_dy = $signed({i_end_y[CoordBits-1], i_end_y})
                  - $signed({i_begin_y[CoordBits-1], i_begin_y});

    always_comb begin
        w_g0.bx    = i_begin_x;
        w_g0.by    = i_begin_y;
        w_g0.ex    = i_end_x;
        w_g0.ey    = i_end_y;
        w_g0.neg_x = w_dx[CoordBits];
        w_g0.neg_y = w_dy[CoordBits];
        w_g0.degen = (w_dx == '0) && (w_dy == '0);
        w_g0.mx    = w_dx[CoordBits] ? MagBits'(-w_dx) : MagBits'(w_dx);
        w_g0.my    = w_dy[CoordBits] ? MagBits'(-w_dy) : MagBits'(w_dy);
    end

    logic  r_s1_v, r_s2_v, r_s3_v;
    t_geom r_s1_g, r_s2_g, r_s3_g;
    logic [SqBits-1:0]  r_s2_sqx, r_s2_sqy;
    logic [SqBits:0]    r_s3_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    // Stages 2 and 3: squares, then the squared length.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_g   <= w_g0;
            r_s2_g   <= r_s1_g;
            r_s2_sqx <= r_s1_g.mx * r_s1_g.mx;
            r_s2_sqy <= r_s1_g.my * r_s1_g.my;
            r_s3_g   <= r_s2_g;
            r_s3_rad <= {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};
        end
    end

    // Square root of rad * 2^16, one result bit per stage.
    logic                r_sr_v    [SqrtSteps];
    t_geom               r_sr_g    [SqrtSteps];
    logic [RemBits-1:0]  r_sr_rem  [SqrtSteps];
    logic [RootBits-1:0] r_sr_root [SqrtSteps];
    logic [PadBits-1:0]  r_sr_x    [SqrtSteps];
    logic [RemBits-1:0]  w_sr_rem  [SqrtSteps];
    logic [RootBits-1:0] w_sr_root [SqrtSteps];
    logic [PadBits-1:0]  w_sr_x    [SqrtSteps];

    always_comb begin
        logic [RemBits-1:0]  p_rem;
        logic [RootBits-1:0] p_root;
        logic [PadBits-1:0]  p_x;
        logic [RemBits-1:0]  rem2;
        logic [RemBits-1:0]  trial;
        for (int k = 0; k < SqrtSteps; k++) begin
            if (k == 0) begin
                p_rem  = '0;
                p_root = '0;
                p_x    = PadBits'({r_s3_rad, 16'b0});
            end else begin
                p_rem  = r_sr_rem[k-1];
                p_root = r_sr_root[k-1];
                p_x    = r_sr_x[k-1];
            end
            rem2  = {p_rem[RemBits-3:0], p_x[PadBits-1 -: 2]};
            trial = RemBits'({p_root, 2'b01});
            if (rem2 >= trial) begin
                w_sr_rem[k]  = rem2 - trial;
                w_sr_root[k] = {p_root[RootBits-2:0], 1'b1};
            end else begin
                w_sr_rem[k]  = rem2;
                w_sr_root[k] = {p_root[RootBits-2:0], 1'b0};
            end
            w_sr_x[k] = {p_x[PadBits-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SqrtSteps; k++) begin
                r_sr_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_sr_v[0] <= r_s3_v;
            for (int k = 1; k < SqrtSteps; k++) begin
                r_sr_v[k] <= r_sr_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sr_g[0] <= r_s3_g;
            for (int k = 1; k < SqrtSteps; k++) begin
                r_sr_g[k] <= r_sr_g[k-1];
            end
            for (int k = 0; k < SqrtSteps; k++) begin
                r_sr_rem[k]  <= w_sr_rem[k];
                r_sr_root[k] <= w_sr_root[k];
                r_sr_x[k]    <= w_sr_x[k];
            end
        end
    end

    // Divide setup: numerators with the half-length rounding term.
    logic [RootBits-1:0] w_len;
    logic [NumBits-1:0]  w_numx, w_numy;
    assign w_len  = r_sr_root[SqrtSteps-1];
    assign w_numx = {1'b0, r_sr_g[SqrtSteps-1].mx, 23'b0} + NumBits'(w_len >> 1);
    assign w_numy = {1'b0, r_sr_g[SqrtSteps-1].my, 23'b0} + NumBits'(w_len >> 1);

    logic                  r_dn_v;
    t_geom                 r_dn_g;
    logic [RootBits-1:0]   r_dn_len;
    logic [NumBits-1:0]    r_dn_nx, r_dn_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dn_v <= 1'b0;
        end else if (w_adv) begin
            r_dn_v <= r_sr_v[SqrtSteps-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dn_g   <= r_sr_g[SqrtSteps-1];
            r_dn_len <= w_len;
            r_dn_nx  <= w_numx;
            r_dn_ny  <= w_numy;
        end
    end

    // Restoring divide, one quotient bit per stage, an x and a y lane.
    logic                  r_dv_v   [UBits];
    t_geom                 r_dv_g   [UBits];
    logic [RootBits-1:0]   r_dv_len [UBits];
    logic [DivRemBits-1:0] r_dv_rx  [UBits];
    logic [DivRemBits-1:0] r_dv_ry  [UBits];
    logic [UBits-1:0]      r_dv_lx  [UBits];
    logic [UBits-1:0]      r_dv_ly  [UBits];
    logic [UBits-1:0]      r_dv_qx  [UBits];
    logic [UBits-1:0]      r_dv_qy  [UBits];
    logic [DivRemBits-1:0] w_dv_rx  [UBits];
    logic [DivRemBits-1:0] w_dv_ry  [UBits];
    logic [UBits-1:0]      w_dv_qx  [UBits];
    logic [UBits-1:0]      w_dv_qy  [UBits];

    always_comb begin
        logic [DivRemBits-1:0] prx, pry, r2x, r2y, dlen;
        logic [UBits-1:0]      plx, ply, pqx, pqy;
        for (int j = 0; j < UBits; j++) begin
            if (j == 0) begin
                prx  = DivRemBits'(r_dn_nx[NumBits-1:UBits]);
                pry  = DivRemBits'(r_dn_ny[NumBits-1:UBits]);
                plx  = r_dn_nx[UBits-1:0];
                ply  = r_dn_ny[UBits-1:0];
                pqx  = '0;
                pqy  = '0;
                dlen = DivRemBits'(r_dn_len);
            end else begin
                prx  = r_dv_rx[j-1];
                pry  = r_dv_ry[j-1];
                plx  = r_dv_lx[j-1];
                ply  = r_dv_ly[j-1];
                pqx  = r_dv_qx[j-1];
                pqy  = r_dv_qy[j-1];
                dlen = DivRemBits'(r_dv_len[j-1]);
            end
            r2x = {prx[DivRemBits-2:0], plx[UBits-1-j]};
            r2y = {pry[DivRemBits-2:0], ply[UBits-1-j]};
            if (r2x >= dlen) begin
                w_dv_rx[j] = r2x - dlen;
                w_dv_qx[j] = {pqx[UBits-2:0], 1'b1};
            end else begin
                w_dv_rx[j] = r2x;
                w_dv_qx[j] = {pqx[UBits-2:0], 1'b0};
            end
            if (r2y >= dlen) begin
                w_dv_ry[j] = r2y - dlen;
                w_dv_qy[j] = {pqy[UBits-2:0], 1'b1};
            end else begin
                w_dv_ry[j] = r2y;
                w_dv_qy[j] = {pqy[UBits-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < UBits; j++) begin
                r_dv_v[j] <= 1'b0;
            end
        end else if (w_adv) begin
            r_dv_v[0] <= r_dn_v;
            for (int j = 1; j < UBits; j++) begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_g[0]   <= r_dn_g;
            r_dv_len[0] <= r_dn_len;
            r_dv_lx[0]  <= r_dn_nx[UBits-1:0];
            r_dv_ly[0]  <= r_dn_ny[UBits-1:0];
            for (int j = 1; j < UBits; j++) begin
                r_dv_g[j]   <= r_dv_g[j-1];
                r_dv_len[j] <= r_dv_len[j-1];
                r_dv_lx[j]  <= r_dv_lx[j-1];
                r_dv_ly[j]  <= r_dv_ly[j-1];
            end
            for (int j = 0; j < UBits; j++) begin
                r_dv_rx[j] <= w_dv_rx[j];
                r_dv_ry[j] <= w_dv_ry[j];
                r_dv_qx[j] <= w_dv_qx[j];
                r_dv_qy[j] <= w_dv_qy[j];
            end
        end
    end

    // Multiply the unit vector magnitudes by the thickness. A zero-length segment has a
    // zero root, so its quotient means nothing and is forced to zero.
    t_geom               w_dg;
    logic                r_mu_v;
    t_geom               r_mu_g;
    logic [ProdBits-1:0] r_mu_px, r_mu_py;
    assign w_dg = r_dv_g[UBits-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_v <= 1'b0;
        end else if (w_adv) begin
            r_mu_v <= r_dv_v[UBits-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mu_g  <= w_dg;
            r_mu_px <= w_dg.degen ? '0 : r_thick * r_dv_qx[UBits-1];
            r_mu_py <= w_dg.degen ? '0 : r_thick * r_dv_qy[UBits-1];
        end
    end

    // Round half away from zero on the magnitude, then apply the signs.
    logic [OffBits-1:0] w_ax16, w_ay16, w_ax17, w_ay17;
    logic signed [OffBits-1:0] w_sx16, w_sy16, w_sx17, w_sy17;
    t_offs w_offs;

    assign w_ax16 = OffBits'((r_mu_px + ProdBits'(1 << 15)) >> 16);
    assign w_ay16 = OffBits'((r_mu_py + ProdBits'(1 << 15)) >> 16);
    assign w_ax17 = OffBits'((r_mu_px + ProdBits'(1 << 16)) >> 17);
    assign w_ay17 = OffBits'((r_mu_py + ProdBits'(1 << 16)) >> 17);
    assign w_sx16 = r_mu_g.neg_x ? -$signed(w_ax16) : $signed(w_ax16);
    assign w_sy16 = r_mu_g.neg_y ? -$signed(w_ay16) : $signed(w_ay16);
    assign w_sx17 = r_mu_g.neg_x ? -$signed(w_ax17) : $signed(w_ax17);
    assign w_sy17 = r_mu_g.neg_y ? -$signed(w_ay17) : $signed(w_ay17);

    always_comb begin
        w_offs.px = -w_sy16;
        w_offs.py = w_sx16;
        w_offs.hx = -w_sy17;
        w_offs.hy = w_sx17;
        w_offs.fx = w_sx16;
        w_offs.fy = w_sy16;
    end

    t_geom r_rd_g;
    t_offs r_rd_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else if (w_adv) begin
            r_rd_v <= r_mu_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd_g <= r_mu_g;
            r_rd_o <= w_offs;
        end
    end

    // Vertex serializer: holds one segment and walks through its twelve vertices.
    t_geom r_ser_g;
    t_offs r_ser_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_v <= 1'b0;
            r_cnt   <= '0;
        end else if (w_ser_load) begin
            r_ser_v <= 1'b1;
            r_cnt   <= '0;
        end else if (w_ser_fin) begin
            r_ser_v <= 1'b0;
        end else if (w_emit) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ser_load) begin
            r_ser_g <= r_rd_g;
            r_ser_o <= r_rd_o;
        end
    end

    // Vertex sums: base point plus up to two offset terms, then saturation.
    logic signed [CoordBits-1:0] w_bsx, w_bsy;
    logic signed [OffBits-1:0]   w_ax, w_ay, w_bx, w_by;
    logic signed [SumBits-1:0]   w_sumx, w_sumy;
    logic signed [CoordBits-1:0] w_vx, w_vy;

    always_comb begin
        w_bsx = r_ser_g.ex;
        w_bsy = r_ser_g.ey;
        w_ax  = '0;
        w_ay  = '0;
        w_bx  = '0;
        w_by  = '0;
        unique case (r_cnt)
            4'd0, 4'd5: begin
                w_bsx = r_ser_g.bx;
                w_bsy = r_ser_g.by;
                w_ax  = -r_ser_o.px;
                w_ay  = -r_ser_o.py;
            end
            4'd4: begin
                w_bsx = r_ser_g.bx;
                w_bsy = r_ser_g.by;
                w_ax  = r_ser_o.px;
                w_ay  = r_ser_o.py;
            end
            4'd1, 4'd6, 4'd11: begin
                w_ax = -r_ser_o.px;
                w_ay = -r_ser_o.py;
            end
            4'd2, 4'd3, 4'd10: begin
                w_ax = r_ser_o.px;
                w_ay = r_ser_o.py;
            end
            4'd7: begin
                w_ax = r_ser_o.fx;
                w_ay = r_ser_o.fy;
                w_bx = -r_ser_o.hx;
                w_by = -r_ser_o.hy;
            end
            4'd8, 4'd9: begin
                w_ax = r_ser_o.fx;
                w_ay = r_ser_o.fy;
                w_bx = r_ser_o.hx;
                w_by = r_ser_o.hy;
            end
            default: begin
                w_ax = '0;
            end
        endcase
        w_sumx = SumBits'(w_bsx) + SumBits'(w_ax) + SumBits'(w_bx);
        w_sumy = SumBits'(w_bsy) + SumBits'(w_ay) + SumBits'(w_by);
    end

    localparam logic signed [SumBits-1:0] SatHi = SumBits'((1 << (CoordBits - 1)) - 1);
    localparam logic signed [SumBits-1:0] SatLo = -SatHi - SumBits'(1);

    always_comb begin
        if (w_sumx > SatHi) begin
            w_vx = CoordBits'(SatHi);
        end else if (w_sumx < SatLo) begin
            w_vx = CoordBits'(SatLo);
        end else begin
            w_vx = CoordBits'(w_sumx);
        end
        if (w_sumy > SatHi) begin
            w_vy = CoordBits'(SatHi);
        end else if (w_sumy < SatLo) begin
            w_vy = CoordBits'(SatLo);
        end else begin
            w_vy = CoordBits'(w_sumy);
        end
    end

    // Output register.
    logic signed [CoordBits-1:0] r_o_x, r_o_y;
    logic [IdxBits-1:0]          r_o_idx;
    logic                        r_o_last, r_o_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_emit) begin
            r_o_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_x     <= w_vx;
            r_o_y     <= w_vy;
            r_o_idx   <= r_cnt;
            r_o_last  <= (r_cnt == LastIdx);
            r_o_degen <= r_ser_g.degen;
        end
    end

    assign o_out_valid    = r_o_v;
    assign o_vertex_x     = r_o_x;
    assign o_vertex_y     = r_o_y;
    assign o_vertex_index = r_o_idx;
    assign o_last_vertex  = r_o_last;
    assign o_degenerate   = r_o_degen;

    // The last flag marks exactly the twelfth vertex.
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_vertex == (o_vertex_index == LastIdx)))
        else $error("last_vertex does not match vertex_index");

    // The serializer count never leaves the vertex range.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ser_v |-> (r_cnt <= LastIdx))
        else $error("serializer count out of range");

    // A new segment in the serializer starts at vertex zero.
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ser_load |=> (r_ser_v && r_cnt == '0))
        else $error("serializer did not restart at vertex zero");

    // The rounding stage is never overwritten while it still holds a segment.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_v && !w_ser_load) |=> (r_rd_v && $stable(r_rd_o)))
        else $error("finished segment lost before serializer load");

endmodule
